FILE: rtl/core/gqg_pkg.sv
package gqg_pkg;

    // Glyph table geometry.
    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);

    // Packed table entries: metrics {adv_x, adv_y, glyph_w, glyph_h},
    // shape {bearing_left, bearing_top, atlas_u, atlas_v}.
    localparam int METRICS_W = 44;
    localparam int SHAPE_W   = 56;

    // Command codes carried in the opcode field.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_RENDER = 2'd2
    } t_opcode;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_SCALE_X     = 3'd0;
    localparam logic [2:0] REG_SCALE_Y     = 3'd1;
    localparam logic [2:0] REG_INV_ATLAS_W = 3'd2;
    localparam logic [2:0] REG_INV_ATLAS_H = 3'd3;
    localparam logic [2:0] REG_WRAP_X      = 3'd4;
    localparam logic [2:0] REG_WRAP_Y      = 3'd5;

    localparam logic [15:0] WRAP_X_RESET = 16'd1000;
    localparam logic [15:0] WRAP_Y_RESET = 16'd50;

    // Special characters.
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] CH_UNDERSCORE = 8'd95;

    // Index of the final vertex of a quad.
    localparam logic [2:0] VTX_LAST = 3'd5;

    localparam logic [16:0] TEX_MAX = 17'h1FFFF;

    // Clamp a wide signed sum into the signed Q4.24 position range.
    function automatic logic signed [28:0] sat_pos(input logic signed [47:0] v);
        logic signed [47:0] lim_hi;
        logic signed [47:0] lim_lo;
        lim_hi = 48'sd268435455;
        lim_lo = -48'sd268435456;
        if (v > lim_hi) begin
            return 29'sh0FFFFFFF;
        end else if (v < lim_lo) begin
            return 29'sh10000000;
        end
        return v[28:0];
    endfunction

    // Texture far edge: base plus size times reciprocal rounded to Q.16.
    function automatic logic [16:0] tex_end(input logic [16:0] base,
                                            input logic [34:0] prod);
        logic [35:0] rnd;
        logic [28:0] sum;
        rnd = 36'(prod) + 36'd128;
        sum = 29'(base) + 29'(rnd[35:8]);
        if (sum > 29'(TEX_MAX)) begin
            return TEX_MAX;
        end
        return sum[16:0];
    endfunction

endpackage

FILE: rtl/core/glyph_quad_generator.sv
// Glyph quad generator. Each transaction on the input channel is a glyph
// table load, a string start or a character render; only a render produces
// output, six vertex transactions forming two clockwise triangles, the sixth
// flagged by o_last_vertex. A render reads the glyph tables (two
// synchronous RAMs with a registered read), then goes through a multiply
// stage, a position stage and an edge stage, and moves into the quad
// register, which emits one vertex per cycle while the output is ready.
// The pen position is carried from one character to the next, so the input
// is held off from acceptance of a render until its pen update is complete.
// The next character is computed while the current quad is still being
// emitted. Configuration must be written over the APB port only while the
// block is idle; the block itself does not enforce this. Glyph entries hold
// no value until loaded, and no clearing pass runs after reset.
module glyph_quad_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // Command channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_opcode,
    input  logic [7:0]          i_char_code,
    input  logic signed [11:0]  i_adv_x,
    input  logic signed [11:0]  i_adv_y,
    input  logic [9:0]          i_glyph_w,
    input  logic [9:0]          i_glyph_h,
    input  logic signed [10:0]  i_bearing_left,
    input  logic signed [10:0]  i_bearing_top,
    input  logic [16:0]         i_atlas_u,
    input  logic [16:0]         i_atlas_v,
    input  logic signed [28:0]  i_origin_x,
    input  logic signed [28:0]  i_origin_y,

    // Vertex channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [28:0]  o_vertex_x,
    output logic signed [28:0]  o_vertex_y,
    output logic [16:0]         o_tex_u,
    output logic [16:0]         o_tex_v,
    output logic                o_last_vertex
);

    // Configuration registers.
    logic [24:0] r_scale_x;
    logic [24:0] r_scale_y;
    logic [24:0] r_inv_w;
    logic [24:0] r_inv_h;
    logic [15:0] r_wrap_x;
    logic [15:0] r_wrap_y;

    // Pen state.
    logic signed [28:0] r_pen_x;
    logic signed [28:0] r_pen_y;
    logic signed [28:0] r_off_x;
    logic signed [28:0] r_off_y;
    logic signed [28:0] r_start_x;
    logic signed [28:0] r_start_y;

    // Pipeline control.
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_pen_upd;
    logic r_q_valid;
    logic [2:0] r_vcnt;

    // Stage 1 registers.
    logic r_s1_space;
    logic r_s1_under;

    // Stage 2 registers (products).
    logic signed [36:0] r_s2_blsx;
    logic signed [36:0] r_s2_btsy;
    logic signed [37:0] r_s2_axsx;
    logic signed [37:0] r_s2_aysy;
    logic [34:0]        r_s2_gwsx;
    logic [34:0]        r_s2_ghsy;
    logic [34:0]        r_s2_gwiu;
    logic [34:0]        r_s2_ghiv;
    logic [40:0]        r_s2_lim;
    logic [40:0]        r_s2_drop;
    logic [16:0]        r_s2_au;
    logic [16:0]        r_s2_av;
    logic               r_s2_space;
    logic               r_s2_under;

    // Stage 3 registers (left and top edges, first pen update).
    logic signed [28:0] r_s3_xl;
    logic signed [28:0] r_s3_yt;
    logic [16:0]        r_s3_ul;
    logic [16:0]        r_s3_vt;
    logic [16:0]        r_s3_ur;
    logic [16:0]        r_s3_vb;
    logic [34:0]        r_s3_gwsx;
    logic [34:0]        r_s3_ghsy;
    logic [40:0]        r_s3_drop;
    logic signed [28:0] r_s3_offx;
    logic signed [28:0] r_s3_offy;
    logic               r_s3_brk;

    // Quad register.
    logic signed [28:0] r_q_xl;
    logic signed [28:0] r_q_xr;
    logic signed [28:0] r_q_yt;
    logic signed [28:0] r_q_yb;
    logic [16:0]        r_q_ul;
    logic [16:0]        r_q_ur;
    logic [16:0]        r_q_vt;
    logic [16:0]        r_q_vb;

    logic in_fire;
    logic out_fire;
    logic q_take;
    logic cfg_write;
    logic is_load;
    logic is_start;
    logic is_render;
    logic [7:0] render_code;

    logic [gqg_pkg::GLYPH_AW-1:0]  wr_addr;
    logic [gqg_pkg::GLYPH_AW-1:0]  rd_addr;
    logic [gqg_pkg::METRICS_W-1:0] metrics_wdata;
    logic [gqg_pkg::METRICS_W-1:0] metrics_rdata;
    logic [gqg_pkg::SHAPE_W-1:0]   shape_wdata;
    logic [gqg_pkg::SHAPE_W-1:0]   shape_rdata;

    logic signed [11:0] m_ax;
    logic signed [11:0] m_ay;
    logic [9:0]         m_gw;
    logic [9:0]         m_gh;
    logic signed [10:0] s_bl;
    logic signed [10:0] s_bt;
    logic [16:0]        s_au;
    logic [16:0]        s_av;

    logic signed [28:0] s2_xl;
    logic signed [28:0] s2_yt;
    logic signed [28:0] s2_offx;
    logic signed [28:0] s2_offy;
    logic               s2_brk;
    logic signed [28:0] s3_xr;
    logic signed [28:0] s3_yb;
    logic signed [28:0] s3_offx;
    logic signed [28:0] s3_offy;

    logic use_right;
    logic use_top;

    // Handshakes.
    assign o_in_ready = !(r_s1_valid || r_s2_valid || r_s3_valid || r_pen_upd);
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_load    = (i_opcode == gqg_pkg::OP_LOAD);
    assign is_start   = (i_opcode == gqg_pkg::OP_START);
    assign is_render  = (i_opcode == gqg_pkg::OP_RENDER);
    assign out_fire   = r_q_valid && i_out_ready;
    assign q_take     = r_s3_valid &&
                        (!r_q_valid || (out_fire && r_vcnt == gqg_pkg::VTX_LAST));

    // APB register file.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[4:2])
            gqg_pkg::REG_SCALE_X:     prdata = 32'(r_scale_x);
            gqg_pkg::REG_SCALE_Y:     prdata = 32'(r_scale_y);
            gqg_pkg::REG_INV_ATLAS_W: prdata = 32'(r_inv_w);
            gqg_pkg::REG_INV_ATLAS_H: prdata = 32'(r_inv_h);
            gqg_pkg::REG_WRAP_X:      prdata = 32'(r_wrap_x);
            gqg_pkg::REG_WRAP_Y:      prdata = 32'(r_wrap_y);
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= '0;
            r_scale_y <= '0;
            r_inv_w   <= '0;
            r_inv_h   <= '0;
            r_wrap_x  <= gqg_pkg::WRAP_X_RESET;
            r_wrap_y  <= gqg_pkg::WRAP_Y_RESET;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                gqg_pkg::REG_SCALE_X:     r_scale_x <= pwdata[24:0];
                gqg_pkg::REG_SCALE_Y:     r_scale_y <= pwdata[24:0];
                gqg_pkg::REG_INV_ATLAS_W: r_inv_w   <= pwdata[24:0];
                gqg_pkg::REG_INV_ATLAS_H: r_inv_h   <= pwdata[24:0];
                gqg_pkg::REG_WRAP_X:      r_wrap_x  <= pwdata[15:0];
                gqg_pkg::REG_WRAP_Y:      r_wrap_y  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Glyph tables. Underscore is drawn with the space glyph.
    assign render_code = (i_char_code == gqg_pkg::CH_UNDERSCORE) ?
                         gqg_pkg::CH_SPACE : i_char_code;
    assign wr_addr = gqg_pkg::GLYPH_AW'(i_char_code);
    assign rd_addr = gqg_pkg::GLYPH_AW'(render_code);
    assign metrics_wdata = {i_adv_x, i_adv_y, i_glyph_w, i_glyph_h};
    assign shape_wdata   = {i_bearing_left, i_bearing_top, i_atlas_u, i_atlas_v};

    gqg_ram #(
        .WIDTH (gqg_pkg::METRICS_W),
        .DEPTH (gqg_pkg::GLYPH_COUNT)
    ) u_metrics_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && is_load),
        .i_waddr (wr_addr),
        .i_wdata (metrics_wdata),
        .i_raddr (rd_addr),
        .o_rdata (metrics_rdata)
    );

    gqg_ram #(
        .WIDTH (gqg_pkg::SHAPE_W),
        .DEPTH (gqg_pkg::GLYPH_COUNT)
    ) u_shape_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && is_load),
        .i_waddr (wr_addr),
        .i_wdata (shape_wdata),
        .i_raddr (rd_addr),
        .o_rdata (shape_rdata)
    );

    // Stage 1: unpack the table entries.
    assign m_ax = metrics_rdata[43:32];
    assign m_ay = metrics_rdata[31:20];
    assign m_gw = metrics_rdata[19:10];
    assign m_gh = metrics_rdata[9:0];
    assign s_bl = shape_rdata[55:45];
    assign s_bt = shape_rdata[44:34];
    assign s_au = shape_rdata[33:17];
    assign s_av = shape_rdata[16:0];

    // Stage 2: left and top edges, texture far edges, pen offset advance.
    assign s2_xl   = gqg_pkg::sat_pos(48'(r_pen_x) + 48'(r_s2_blsx));
    assign s2_yt   = gqg_pkg::sat_pos(48'(r_pen_y) + 48'(r_s2_btsy));
    assign s2_offx = gqg_pkg::sat_pos(48'(r_off_x) + 48'(r_s2_axsx));
    assign s2_offy = gqg_pkg::sat_pos(48'(r_off_y) - 48'(r_s2_aysy));
    assign s2_brk  = ((48'(s2_offx) > $signed({7'd0, r_s2_lim})) && r_s2_space) ||
                     r_s2_under;

    // Stage 3: right and bottom edges, line break.
    assign s3_xr = gqg_pkg::sat_pos(48'(r_s3_xl) + $signed({13'd0, r_s3_gwsx}));
    assign s3_yb = gqg_pkg::sat_pos(48'(r_s3_yt) - $signed({13'd0, r_s3_ghsy}));
    assign s3_offx = r_s3_brk ? 29'sd0 : r_s3_offx;
    assign s3_offy = r_s3_brk ?
                     gqg_pkg::sat_pos(48'(r_s3_offy) - $signed({7'd0, r_s3_drop})) :
                     r_s3_offy;

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_space <= (i_char_code == gqg_pkg::CH_SPACE);
            r_s1_under <= (i_char_code == gqg_pkg::CH_UNDERSCORE);
        end
        if (r_s1_valid) begin
            r_s2_blsx  <= $signed(s_bl) * $signed({1'b0, r_scale_x});
            r_s2_btsy  <= $signed(s_bt) * $signed({1'b0, r_scale_y});
            r_s2_axsx  <= $signed(m_ax) * $signed({1'b0, r_scale_x});
            r_s2_aysy  <= $signed(m_ay) * $signed({1'b0, r_scale_y});
            r_s2_gwsx  <= m_gw * r_scale_x;
            r_s2_ghsy  <= m_gh * r_scale_y;
            r_s2_gwiu  <= m_gw * r_inv_w;
            r_s2_ghiv  <= m_gh * r_inv_h;
            r_s2_lim   <= r_wrap_x * r_scale_x;
            r_s2_drop  <= r_wrap_y * r_scale_y;
            r_s2_au    <= s_au;
            r_s2_av    <= s_av;
            r_s2_space <= r_s1_space;
            r_s2_under <= r_s1_under;
        end
        if (r_s2_valid) begin
            r_s3_xl   <= s2_xl;
            r_s3_yt   <= s2_yt;
            r_s3_ul   <= r_s2_au;
            r_s3_vt   <= r_s2_av;
            r_s3_ur   <= gqg_pkg::tex_end(r_s2_au, r_s2_gwiu);
            r_s3_vb   <= gqg_pkg::tex_end(r_s2_av, r_s2_ghiv);
            r_s3_gwsx <= r_s2_gwsx;
            r_s3_ghsy <= r_s2_ghsy;
            r_s3_drop <= r_s2_drop;
            r_s3_offx <= s2_offx;
            r_s3_offy <= s2_offy;
            r_s3_brk  <= s2_brk;
        end
        if (q_take) begin
            r_q_xl <= r_s3_xl;
            r_q_xr <= s3_xr;
            r_q_yt <= r_s3_yt;
            r_q_yb <= s3_yb;
            r_q_ul <= r_s3_ul;
            r_q_ur <= r_s3_ur;
            r_q_vt <= r_s3_vt;
            r_q_vb <= r_s3_vb;
        end
    end

    // Pen state: a string start resets it, a render commits its advance
    // when its quad is taken, and the absolute pen follows in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x   <= '0;
            r_pen_y   <= '0;
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
        end else begin
            if (in_fire && is_start) begin
                r_start_x <= i_origin_x;
                r_start_y <= i_origin_y;
                r_pen_x   <= i_origin_x;
                r_pen_y   <= i_origin_y;
                r_off_x   <= '0;
                r_off_y   <= '0;
            end
            if (q_take) begin
                r_off_x <= s3_offx;
                r_off_y <= s3_offy;
            end
            if (r_pen_upd) begin
                r_pen_x <= gqg_pkg::sat_pos(48'(r_start_x) + 48'(r_off_x));
                r_pen_y <= gqg_pkg::sat_pos(48'(r_start_y) + 48'(r_off_y));
            end
        end
    end

    // Pipeline control and vertex counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_pen_upd  <= 1'b0;
            r_q_valid  <= 1'b0;
            r_vcnt     <= '0;
        end else begin
            r_s1_valid <= in_fire && is_render;
            r_s2_valid <= r_s1_valid;
            r_pen_upd  <= q_take;
            if (r_s2_valid) begin
                r_s3_valid <= 1'b1;
            end else if (q_take) begin
                r_s3_valid <= 1'b0;
            end
            if (q_take) begin
                r_q_valid <= 1'b1;
            end else if (out_fire && r_vcnt == gqg_pkg::VTX_LAST) begin
                r_q_valid <= 1'b0;
            end
            if (out_fire) begin
                r_vcnt <= (r_vcnt == gqg_pkg::VTX_LAST) ? 3'd0 : r_vcnt + 3'd1;
            end
        end
    end

    // Vertex order: left-bottom, left-top, right-bottom, right-bottom,
    // left-top, right-top.
    always_comb begin
        unique case (r_vcnt)
            3'd0:    begin use_right = 1'b0; use_top = 1'b0; end
            3'd1:    begin use_right = 1'b0; use_top = 1'b1; end
            3'd2:    begin use_right = 1'b1; use_top = 1'b0; end
            3'd3:    begin use_right = 1'b1; use_top = 1'b0; end
            3'd4:    begin use_right = 1'b0; use_top = 1'b1; end
            default: begin use_right = 1'b1; use_top = 1'b1; end
        endcase
    end

    assign o_out_valid   = r_q_valid;
    assign o_vertex_x    = use_right ? r_q_xr : r_q_xl;
    assign o_vertex_y    = use_top   ? r_q_yt : r_q_yb;
    assign o_tex_u       = use_right ? r_q_ur : r_q_ul;
    assign o_tex_v       = use_top   ? r_q_vt : r_q_vb;
    assign o_last_vertex = (r_vcnt == gqg_pkg::VTX_LAST);

`ifndef NO_ASSERTIONS
    // At most one render is in flight ahead of its pen update.
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_s1_valid, r_s2_valid, r_s3_valid, r_pen_upd}))
        else $error("more than one render in the pen path");

    // An accepted render enters the table read stage.
    a_render_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_render) |=> r_s1_valid)
        else $error("accepted render did not enter the pipeline");

    // A finished quad moves into an empty quad register at once.
    a_quad_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !r_q_valid) |=> (r_q_valid && !r_s3_valid))
        else $error("finished quad did not move to the quad register");

    // The vertex counter restarts whenever a new quad is loaded.
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_take |=> (r_vcnt == 3'd0))
        else $error("vertex counter not at zero for a new quad");
`endif

endmodule

FILE: rtl/core/gqg_ram.sv
module gqg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/glyph_quad_checker.sv
`timescale 1ns / 100ps

// Watches the configuration port and both channels of the glyph quad generator,
// predicts the six vertices of every rendered character and compares them in order.
module glyph_quad_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,

    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_char_code,
    input  logic signed [11:0] i_adv_x,
    input  logic signed [11:0] i_adv_y,
    input  logic [9:0]         i_glyph_w,
    input  logic [9:0]         i_glyph_h,
    input  logic signed [10:0] i_bearing_left,
    input  logic signed [10:0] i_bearing_top,
    input  logic [16:0]        i_atlas_u,
    input  logic [16:0]        i_atlas_v,
    input  logic signed [28:0] i_origin_x,
    input  logic signed [28:0] i_origin_y,

    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic signed [28:0] o_vertex_x,
    input  logic signed [28:0] o_vertex_y,
    input  logic [16:0]        o_tex_u,
    input  logic [16:0]        o_tex_v,
    input  logic               o_last_vertex,

    output int                 fail_count,
    output int                 pending_count,
    output int                 vertex_count
);

    localparam longint POS_HI = 64'sd268435455;
    localparam longint POS_LO = -64'sd268435456;

    typedef struct {
        logic signed [11:0] adv_x;
        logic signed [11:0] adv_y;
        logic [9:0]         width;
        logic [9:0]         height;
        logic signed [10:0] bear_l;
        logic signed [10:0] bear_t;
        logic [16:0]        atlas_u;
        logic [16:0]        atlas_v;
    } t_glyph;

    typedef struct {
        logic signed [28:0] x;
        logic signed [28:0] y;
        logic [16:0]        u;
        logic [16:0]        v;
        logic               last_vtx;
    } t_vertex;

    t_glyph      glyph_tab [gqg_pkg::GLYPH_COUNT];
    t_vertex     quad_vertices [$];
    logic [24:0] scale_x, scale_y, inv_w, inv_h;
    logic [15:0] wrap_x, wrap_y;
    longint      start_x, start_y, pen_x, pen_y, off_x, off_y;

    // Clamp to the signed Q4.24 range.
    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) begin
            return POS_HI;
        end
        if (v < POS_LO) begin
            return POS_LO;
        end
        return v;
    endfunction

    // Far texture edge: extent rounded from Q.24 to Q.16, then saturated.
    function automatic longint tex_far(input longint base, input longint size,
                                       input longint recip);
        longint edge_pos;
        edge_pos = base + ((size * recip + 128) >>> 8);
        return (edge_pos > longint'(gqg_pkg::TEX_MAX)) ?
               longint'(gqg_pkg::TEX_MAX) : edge_pos;
    endfunction

    task automatic push_vertex(input longint x, input longint y, input longint u,
                               input longint v, input logic fin);
        t_vertex vtx;
        vtx.x        = x[28:0];
        vtx.y        = y[28:0];
        vtx.u        = u[16:0];
        vtx.v        = v[16:0];
        vtx.last_vtx = fin;
        quad_vertices.push_back(vtx);
    endtask

    // Build the quad at the current pen, then advance the pen and apply line breaks.
    task automatic predict_quad(input logic [7:0] code);
        int     idx;
        t_glyph g;
        longint sx, sy, xl, xr, yt, yb, ur, vb;
        idx = int'((code == gqg_pkg::CH_UNDERSCORE) ? gqg_pkg::CH_SPACE : code) %
              gqg_pkg::GLYPH_COUNT;
        g   = glyph_tab[idx];
        sx  = longint'(scale_x);
        sy  = longint'(scale_y);
        xl  = clamp_pos(pen_x + longint'(g.bear_l) * sx);
        yt  = clamp_pos(pen_y + longint'(g.bear_t) * sy);
        yb  = clamp_pos(yt - longint'(g.height) * sy);
        xr  = clamp_pos(xl + longint'(g.width) * sx);
        ur  = tex_far(longint'(g.atlas_u), longint'(g.width), longint'(inv_w));
        vb  = tex_far(longint'(g.atlas_v), longint'(g.height), longint'(inv_h));

        off_x = clamp_pos(off_x + longint'(g.adv_x) * sx);
        off_y = clamp_pos(off_y - longint'(g.adv_y) * sy);
        if ((code == gqg_pkg::CH_SPACE && off_x > longint'(wrap_x) * sx) ||
            code == gqg_pkg::CH_UNDERSCORE) begin
            off_x = 0;
            off_y = clamp_pos(off_y - longint'(wrap_y) * sy);
        end
        pen_x = clamp_pos(start_x + off_x);
        pen_y = clamp_pos(start_y + off_y);

        // Two clockwise triangles.
        push_vertex(xl, yb, g.atlas_u, vb, 1'b0);
        push_vertex(xl, yt, g.atlas_u, g.atlas_v, 1'b0);
        push_vertex(xr, yb, ur, vb, 1'b0);
        push_vertex(xr, yb, ur, vb, 1'b0);
        push_vertex(xl, yt, g.atlas_u, g.atlas_v, 1'b0);
        push_vertex(xr, yt, ur, g.atlas_v, 1'b1);
    endtask

    always @(posedge i_clk) begin : monitor
        t_vertex want;
        bit      bad;
        if (!i_rst_n) begin
            scale_x = '0;
            scale_y = '0;
            inv_w   = '0;
            inv_h   = '0;
            wrap_x  = gqg_pkg::WRAP_X_RESET;
            wrap_y  = gqg_pkg::WRAP_Y_RESET;
            start_x = 0;
            start_y = 0;
            pen_x   = 0;
            pen_y   = 0;
            off_x   = 0;
            off_y   = 0;
            quad_vertices.delete();
        end else begin
            // Register writes.
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    gqg_pkg::REG_SCALE_X:     scale_x = pwdata[24:0];
                    gqg_pkg::REG_SCALE_Y:     scale_y = pwdata[24:0];
                    gqg_pkg::REG_INV_ATLAS_W: inv_w   = pwdata[24:0];
                    gqg_pkg::REG_INV_ATLAS_H: inv_h   = pwdata[24:0];
                    gqg_pkg::REG_WRAP_X:      wrap_x  = pwdata[15:0];
                    gqg_pkg::REG_WRAP_Y:      wrap_y  = pwdata[15:0];
                    default: ;
                endcase
            end

            // Vertex transactions are checked before a command accepted at the
            // same edge, since such a vertex always belongs to an older render.
            if (o_out_valid && i_out_ready) begin
                if (quad_vertices.size() == 0) begin
                    $error("unexpected vertex x=%0d y=%0d", o_vertex_x, o_vertex_y);
                    fail_count++;
                end else begin
                    want = quad_vertices.pop_front();
                    bad  = 1'b0;
                    vertex_count++;
                    if (o_vertex_x !== want.x) begin
                        $error("vertex_x: expected %0d, got %0d", want.x, o_vertex_x);
                        bad = 1'b1;
                    end
                    if (o_vertex_y !== want.y) begin
                        $error("vertex_y: expected %0d, got %0d", want.y, o_vertex_y);
                        bad = 1'b1;
                    end
                    if (o_tex_u !== want.u) begin
                        $error("tex_u: expected %0d, got %0d", want.u, o_tex_u);
                        bad = 1'b1;
                    end
                    if (o_tex_v !== want.v) begin
                        $error("tex_v: expected %0d, got %0d", want.v, o_tex_v);
                        bad = 1'b1;
                    end
                    if (o_last_vertex !== want.last_vtx) begin
                        $error("last_vertex: expected %0d, got %0d", want.last_vtx,
                               o_last_vertex);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        fail_count++;
                    end
                end
            end

            // Command transactions.
            if (i_in_valid && o_in_ready) begin
                case (i_opcode)
                    gqg_pkg::OP_LOAD: begin
                        glyph_tab[int'(i_char_code) % gqg_pkg::GLYPH_COUNT] = '{
                            adv_x: i_adv_x, adv_y: i_adv_y,
                            width: i_glyph_w, height: i_glyph_h,
                            bear_l: i_bearing_left, bear_t: i_bearing_top,
                            atlas_u: i_atlas_u, atlas_v: i_atlas_v};
                    end
                    gqg_pkg::OP_START: begin
                        start_x = longint'(i_origin_x);
                        start_y = longint'(i_origin_y);
                        pen_x   = start_x;
                        pen_y   = start_y;
                        off_x   = 0;
                        off_y   = 0;
                    end
                    gqg_pkg::OP_RENDER: begin
                        predict_quad(i_char_code);
                    end
                    default: ;
                endcase
            end
        end
        pending_count = quad_vertices.size();
    end

endmodule

FILE: tb/glyph_quad_generator_test.sv
`timescale 1ns / 100ps

module glyph_quad_generator_test;

    // The fourth opcode value has no meaning and must be ignored.
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         PHASES        = 6;
    localparam int         PHASE_ITEMS   = 48;

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         code;
        logic signed [11:0] adv_x;
        logic signed [11:0] adv_y;
        logic [9:0]         width;
        logic [9:0]         height;
        logic signed [10:0] bear_l;
        logic signed [10:0] bear_t;
        logic [16:0]        atlas_u;
        logic [16:0]        atlas_v;
        logic signed [28:0] org_x;
        logic signed [28:0] org_y;
    } t_cmd;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_opcode = '0;
    logic [7:0]         i_char_code = '0;
    logic signed [11:0] i_adv_x = '0;
    logic signed [11:0] i_adv_y = '0;
    logic [9:0]         i_glyph_w = '0;
    logic [9:0]         i_glyph_h = '0;
    logic signed [10:0] i_bearing_left = '0;
    logic signed [10:0] i_bearing_top = '0;
    logic [16:0]        i_atlas_u = '0;
    logic [16:0]        i_atlas_v = '0;
    logic signed [28:0] i_origin_x = '0;
    logic signed [28:0] i_origin_y = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [28:0] o_vertex_x;
    logic signed [28:0] o_vertex_y;
    logic [16:0]        o_tex_u;
    logic [16:0]        o_tex_v;
    logic               o_last_vertex;

    int fail_count;
    int pending_count;
    int vertex_count;
    int cycle_count = 0;
    int cmds_sent = 0;
    int renders_sent = 0;
    bit no_idle = 1'b0;

    // Glyph indexes loaded so far; renders only use these.
    bit         glyph_loaded [256];
    logic [7:0] loaded_codes [$];

    glyph_quad_generator i_dut (.*);

    glyph_quad_checker u_checker (.*);

    always #5 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("glyph_quad_generator_test: errors");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 3));
    endfunction

    // Vertex receiver: random stall before each transaction, unless no_idle is set.
    initial begin : vertex_sink
        int stall;
        forever begin
            @(negedge i_clk);
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic t_cmd random_cmd(input logic [1:0] op, input logic [7:0] code);
        t_cmd c;
        c.op      = op;
        c.code    = code;
        c.adv_x   = 12'($urandom());
        c.adv_y   = 12'($urandom());
        c.width   = 10'($urandom());
        c.height  = 10'($urandom());
        c.bear_l  = 11'($urandom());
        c.bear_t  = 11'($urandom());
        c.atlas_u = 17'($urandom());
        c.atlas_v = 17'($urandom());
        c.org_x   = 29'($urandom());
        c.org_y   = 29'($urandom());
        return c;
    endfunction

    function automatic t_cmd glyph_load(input logic [7:0] code, input int ax, input int ay,
                                        input int w, input int h, input int bl,
                                        input int bt, input int au, input int av);
        t_cmd c;
        c         = random_cmd(gqg_pkg::OP_LOAD, code);
        c.adv_x   = 12'(ax);
        c.adv_y   = 12'(ay);
        c.width   = 10'(w);
        c.height  = 10'(h);
        c.bear_l  = 11'(bl);
        c.bear_t  = 11'(bt);
        c.atlas_u = 17'(au);
        c.atlas_v = 17'(av);
        return c;
    endfunction

    function automatic t_cmd string_start(input int ox, input int oy);
        t_cmd c;
        c       = random_cmd(gqg_pkg::OP_START, 8'($urandom()));
        c.org_x = 29'(ox);
        c.org_y = 29'(oy);
        return c;
    endfunction

    function automatic t_cmd char_render(input logic [7:0] code);
        return random_cmd(gqg_pkg::OP_RENDER, code);
    endfunction

    // Half of the loads look like real font metrics, the rest use any bits.
    function automatic t_cmd random_load();
        if ($urandom_range(0, 1) == 0) begin
            return random_cmd(gqg_pkg::OP_LOAD, 8'($urandom()));
        end
        return glyph_load(8'($urandom()), $urandom_range(0, 60), $urandom_range(0, 8) - 4,
                          $urandom_range(0, 64), $urandom_range(0, 64),
                          $urandom_range(0, 8) - 2, $urandom_range(0, 64),
                          $urandom_range(0, 65536), $urandom_range(0, 65536));
    endfunction

    // Origins mostly on screen, sometimes anywhere in the Q4.24 range.
    function automatic t_cmd random_start();
        if ($urandom_range(0, 2) == 0) begin
            return random_cmd(gqg_pkg::OP_START, 8'($urandom()));
        end
        return string_start(int'($urandom_range(0, 33554432)) - 16777216,
                            int'($urandom_range(0, 33554432)) - 16777216);
    endfunction

    // Send one command transaction; starts and ends at a falling edge.
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= c.op;
        i_char_code    <= c.code;
        i_adv_x        <= c.adv_x;
        i_adv_y        <= c.adv_y;
        i_glyph_w      <= c.width;
        i_glyph_h      <= c.height;
        i_bearing_left <= c.bear_l;
        i_bearing_top  <= c.bear_t;
        i_atlas_u      <= c.atlas_u;
        i_atlas_v      <= c.atlas_v;
        i_origin_x     <= c.org_x;
        i_origin_y     <= c.org_y;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (c.op != OP_UNUSED) begin
            cmds_sent++;
        end
        if (c.op == gqg_pkg::OP_RENDER) begin
            renders_sent++;
        end
        if (c.op == gqg_pkg::OP_LOAD && !glyph_loaded[c.code]) begin
            glyph_loaded[c.code] = 1'b1;
            loaded_codes.push_back(c.code);
        end
    endtask

    // Register write: setup phase, access phase, then an idle phase.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [24:0] sx, input logic [24:0] sy,
                              input logic [24:0] iw, input logic [24:0] ih,
                              input logic [15:0] wx, input logic [15:0] wy);
        reg_write(gqg_pkg::REG_SCALE_X, 32'(sx));
        reg_write(gqg_pkg::REG_SCALE_Y, 32'(sy));
        reg_write(gqg_pkg::REG_INV_ATLAS_W, 32'(iw));
        reg_write(gqg_pkg::REG_INV_ATLAS_H, 32'(ih));
        reg_write(gqg_pkg::REG_WRAP_X, 32'(wx));
        reg_write(gqg_pkg::REG_WRAP_Y, 32'(wy));
    endtask

    // Register settings per phase: an 800x600 screen with a 512 pixel atlas,
    // all ones, all zeros, then random mixes.
    task automatic set_config(input int phase);
        case (phase)
            0, 1: write_regs(25'd41943, 25'd55924, 25'd32768, 25'd32768, 16'd200, 16'd20);
            2: write_regs('1, '1, '1, '1, '1, '1);
            3: write_regs('0, '0, '0, '0, '0, '0);
            4: write_regs(25'($urandom_range(0, 200000)), 25'($urandom_range(0, 200000)),
                          25'($urandom_range(0, 16777216)),
                          25'($urandom_range(0, 16777216)),
                          16'($urandom_range(0, 400)), 16'($urandom_range(0, 100)));
            5: write_regs(25'($urandom_range(0, 100000)), 25'($urandom_range(0, 100000)),
                          25'd16777216, 25'd16777216, 16'($urandom()), 16'($urandom()));
            default: write_regs(25'($urandom()), 25'($urandom()), 25'($urandom()),
                                25'($urandom()), 16'($urandom()), 16'($urandom()));
        endcase
    endtask

    // Wait until every predicted vertex has arrived and the pipeline is empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly strings of renders from loaded glyphs, mixed with loads,
    // restarts and ignored commands.
    task automatic random_phase(input int count);
        int         done;
        int         pick;
        t_cmd       c;
        logic [7:0] code;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                c = random_load();
            end else if (pick < 22) begin
                c = random_start();
            end else if (pick < 25) begin
                c = random_cmd(OP_UNUSED, 8'($urandom()));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    code = gqg_pkg::CH_SPACE;
                end else if (pick < 25) begin
                    code = gqg_pkg::CH_UNDERSCORE;
                end else begin
                    code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
                end
                c = char_render(code);
            end
            send_cmd(c);
            if (c.op != OP_UNUSED) begin
                done++;
            end
        end
    endtask

    initial begin : stimulus
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_config(0);

        // Directed: the space glyph breaks a line by itself with this advance,
        // plus glyphs at the field extremes and the extreme origins.
        send_cmd(glyph_load(gqg_pkg::CH_SPACE, 300, 0, 8, 2, 1, 1, 1000, 2000));
        send_cmd(glyph_load(gqg_pkg::CH_UNDERSCORE, 7, 3, 9, 2, 0, -5, 5000, 6000));
        send_cmd(glyph_load(8'd65, 20, 0, 16, 24, 2, 22, 4096, 8192));
        send_cmd(glyph_load(8'd255, 2047, -2048, 1023, 1023, 1023, -1024, 131071, 65536));
        send_cmd(glyph_load(8'd0, -2048, 2047, 0, 0, -1024, 1023, 0, 0));
        send_cmd(random_cmd(OP_UNUSED, 8'd65));
        send_cmd(string_start(-15099494, 15099494));
        send_cmd(char_render(8'd65));
        send_cmd(char_render(8'd65));
        send_cmd(char_render(gqg_pkg::CH_SPACE));
        send_cmd(char_render(gqg_pkg::CH_UNDERSCORE));
        send_cmd(char_render(8'd255));
        send_cmd(char_render(8'd0));
        send_cmd(string_start(268435455, -268435456));
        send_cmd(char_render(8'd255));
        send_cmd(char_render(8'd0));
        send_cmd(string_start(-268435456, 268435455));
        send_cmd(char_render(8'd255));
        send_cmd(char_render(8'd0));
        send_cmd(char_render(gqg_pkg::CH_UNDERSCORE));

        // Random phases, each under its own register setting.
        for (int phase = 1; phase <= PHASES; phase++) begin
            settle();
            set_config(phase);
            no_idle = (phase == 1 || phase == 5);
            random_phase(PHASE_ITEMS);
        end
        no_idle = 1'b0;
        settle();

        $display("Sent %0d commands including %0d character renders over %0d register settings;",
                 cmds_sent, renders_sent, PHASES);
        $display("%0d vertices were compared against the prediction.", vertex_count);
        if (fail_count == 0) begin
            $display("glyph_quad_generator_test: clean");
        end else begin
            $display("glyph_quad_generator_test: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/gqg_pkg.sv
rtl/core/gqg_ram.sv
rtl/core/glyph_quad_generator.sv
tb/glyph_quad_checker.sv
tb/glyph_quad_generator_test.sv
